// ===== rtl/core/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk_i and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property, sampled on the rising clock edge outside reset.
`define SDFS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Same-cycle implication.
`define SDFS_ASSERT_IMPL(lbl, ante, cons, msg) \
  `SDFS_ASSERT(lbl, ante |-> cons, msg)

`endif

// ===== rtl/core/sdfs_pkg.sv =====
// ---------------------------------------------------------------------------
// sdfs_pkg
// Widths, constants and shared types of the screen dim fade sequencer.
// ---------------------------------------------------------------------------
package sdfs_pkg;

  localparam int unsigned NOW_W    = 48;
  localparam int unsigned ALPHA_W  = 32;
  localparam int unsigned BRIGHT_W = 7;
  localparam int unsigned MS_W     = 16;
  localparam int unsigned PADDR_W  = 4;
  localparam int unsigned PDATA_W  = 32;

  localparam logic [ALPHA_W-1:0] BLACK        = 32'hFFFF_FFFF;
  localparam logic [ALPHA_W-1:0] PERCENT_FULL = 32'd100;
  localparam logic [ALPHA_W-1:0] DIM_STEP     = BLACK / PERCENT_FULL;
  localparam logic [ALPHA_W-1:0] CANCEL_MS    = 32'd500;

  localparam logic [BRIGHT_W-1:0] BRIGHT_RST = 7'd50;
  localparam logic [MS_W-1:0]     DIM_RST    = 16'd1000;
  localparam logic [MS_W-1:0]     HOLD_RST   = 16'd5000;

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned DIV_CNT_W   = $clog2(ALPHA_W);

  typedef enum logic [1:0] {
    REG_BRIGHTNESS = 2'd0,
    REG_DIM_MS     = 2'd1,
    REG_HOLD_MS    = 2'd2
  } reg_idx_e;

  typedef struct packed {
    logic [BRIGHT_W-1:0] brightness_percent;
    logic [MS_W-1:0]     dim_ms;
    logic [MS_W-1:0]     hold_ms;
  } cfg_t;

  typedef struct packed {
    logic [NOW_W-1:0]   now_ms;
    logic               cancel_request;
    logic [ALPHA_W-1:0] target;
  } item_t;

  typedef struct packed {
    logic               start;
    logic [ALPHA_W-1:0] num;
    logic [ALPHA_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic               done;
    logic [ALPHA_W-1:0] quot;
  } div_rsp_t;

  typedef struct packed {
    logic [ALPHA_W-1:0] alpha;
    logic               redraw;
    logic               want_next_frame;
    logic               finished;
    logic               cancelled_notify;
  } result_t;

endpackage

// ===== rtl/core/sdfs_in_if.sv =====
// ---------------------------------------------------------------------------
// sdfs_in_if
// Frame event channel: timestamp and cancel flag with valid/ready.
// ---------------------------------------------------------------------------
interface sdfs_in_if import sdfs_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [NOW_W-1:0] now_ms;
  logic             cancel_request;

  modport source (output valid, output now_ms, output cancel_request, input ready);
  modport sink (input valid, input now_ms, input cancel_request, output ready);
endinterface

// ===== rtl/core/sdfs_out_if.sv =====
// ---------------------------------------------------------------------------
// sdfs_out_if
// Result channel: overlay alpha and status flags with valid/ready.
// ---------------------------------------------------------------------------
interface sdfs_out_if import sdfs_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [ALPHA_W-1:0] alpha;
  logic               redraw;
  logic               want_next_frame;
  logic               finished;
  logic               cancelled_notify;

  modport source (output valid, output alpha, output redraw, output want_next_frame,
                  output finished, output cancelled_notify, input ready);
  modport sink (input valid, input alpha, input redraw, input want_next_frame,
                input finished, input cancelled_notify, output ready);
endinterface

// ===== rtl/core/sdfs_queue.sv =====
// ---------------------------------------------------------------------------
// sdfs_queue
// Short register queue between the front and back parts.
// ---------------------------------------------------------------------------
module sdfs_queue import sdfs_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  item_t item_i,
  output logic  ready_o,
  output logic  valid_o,
  output item_t item_o,
  input  logic  pop_i
);

  item_t             mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] cnt_q, cnt_d;
  logic              do_push, do_pop;

  assign ready_o = (cnt_q != QCNT_W'(QUEUE_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign item_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && ready_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

// ===== rtl/core/sdfs_front.sv =====
// ---------------------------------------------------------------------------
// sdfs_front
// Accepts frame events and attaches the target dim level for the back part.
// ---------------------------------------------------------------------------
module sdfs_front import sdfs_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [BRIGHT_W-1:0] brightness_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [NOW_W-1:0]    now_ms_i,
  input  logic                cancel_request_i,
  output logic                push_o,
  output item_t               item_o,
  input  logic                q_ready_i
);

  logic               valid_q;
  item_t              item_q;
  logic [ALPHA_W-1:0] target;

  // Target level wraps modulo 2^32 when brightness exceeds one hundred.
  assign target     = DIM_STEP * (PERCENT_FULL - ALPHA_W'(brightness_i));
  assign in_ready_o = !valid_q || q_ready_i;
  assign push_o     = valid_q;
  assign item_o     = item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_valid_i && in_ready_o) begin
      valid_q <= 1'b1;
    end else if (q_ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q.now_ms         <= now_ms_i;
      item_q.cancel_request <= cancel_request_i;
      item_q.target         <= target;
    end
  end

endmodule

// ===== rtl/core/sdfs_divider.sv =====
// ---------------------------------------------------------------------------
// sdfs_divider
// Iterative restoring divider, one quotient bit per cycle.
// ---------------------------------------------------------------------------
module sdfs_divider import sdfs_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  logic                 run_q;
  logic                 done_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic [ALPHA_W-1:0]   rem_q;
  logic [ALPHA_W-1:0]   quo_q;
  logic [ALPHA_W-1:0]   den_q;
  logic                 den_zero_q;
  logic [ALPHA_W:0]     shifted;
  logic [ALPHA_W+1:0]   trial;
  logic                 fits;
  logic [ALPHA_W-1:0]   rem_d;

  assign shifted = {rem_q, quo_q[ALPHA_W-1]};
  assign trial   = {1'b0, shifted} - {2'b00, den_q};
  assign fits    = !trial[ALPHA_W+1];
  assign rem_d   = fits ? trial[ALPHA_W-1:0] : shifted[ALPHA_W-1:0];

  // A zero divisor yields a zero quotient.
  assign rsp_o.done = done_q;
  assign rsp_o.quot = den_zero_q ? '0 : quo_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        run_q <= 1'b1;
        cnt_q <= '0;
      end else if (run_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == DIV_CNT_W'(ALPHA_W - 1)) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q      <= '0;
      quo_q      <= req_i.num;
      den_q      <= req_i.den;
      den_zero_q <= (req_i.den == '0);
    end else if (run_q) begin
      rem_q <= rem_d;
      quo_q <= {quo_q[ALPHA_W-2:0], fits};
    end
  end

endmodule

// ===== rtl/core/sdfs_back.sv =====
// ---------------------------------------------------------------------------
// sdfs_back
// Steps the fade sequence for one queued event and registers the result.
// ---------------------------------------------------------------------------
module sdfs_back import sdfs_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  cfg_t     cfg_i,
  input  logic     q_valid_i,
  input  item_t    q_item_i,
  output logic     q_pop_o,
  output div_req_t div_req_o,
  input  div_rsp_t div_rsp_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output result_t  out_result_o
);

  typedef enum logic [2:0] {
    PH_DIM_INIT  = 3'd0,
    PH_HOLD      = 3'd1,
    PH_DIM_SLEEP = 3'd2,
    PH_OFF       = 3'd3,
    PH_CANCEL    = 3'd4,
    PH_DONE      = 3'd5
  } phase_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_MUL,
    ST_FIN
  } state_e;

  state_e             state_q;
  phase_e             phase_q, phase_d;
  phase_e             start_phase_q;
  logic [NOW_W-1:0]   sect_q, sect_d;
  logic [ALPHA_W-1:0] capt_q, capt_d;
  item_t              item_q;
  logic [NOW_W-1:0]   elapsed_q;
  logic [ALPHA_W-1:0] quot_q;
  logic [ALPHA_W-1:0] mop_q;
  logic [ALPHA_W-1:0] prod_q;
  logic               out_valid_q;
  result_t            result_q;

  logic               pop;
  logic [NOW_W-1:0]   sect_cur;
  logic [NOW_W-1:0]   elapsed_new;
  logic [ALPHA_W-1:0] mop_d;
  logic [ALPHA_W-1:0] mul_lo;
  logic [ALPHA_W-1:0] alpha_d;
  logic               dim_done, hold_done, cancel_done;

  assign pop         = (state_q == ST_IDLE) && q_valid_i && !out_valid_q;
  assign q_pop_o     = pop;
  assign sect_cur    = (sect_q == '0) ? q_item_i.now_ms : sect_q;
  assign elapsed_new = q_item_i.now_ms - sect_cur;

  always_comb begin
    div_req_o.start = pop;
    div_req_o.num   = '0;
    div_req_o.den   = CANCEL_MS;
    case (phase_q)
      PH_DIM_INIT: begin
        div_req_o.num = q_item_i.target;
        div_req_o.den = ALPHA_W'(cfg_i.dim_ms);
      end
      PH_DIM_SLEEP: begin
        div_req_o.num = BLACK - q_item_i.target;
        div_req_o.den = ALPHA_W'(cfg_i.dim_ms);
      end
      PH_CANCEL: begin
        div_req_o.num = capt_q;
        div_req_o.den = CANCEL_MS;
      end
      default: begin
        div_req_o.num = '0;
        div_req_o.den = CANCEL_MS;
      end
    endcase
  end

  assign mop_d  = (phase_q == PH_CANCEL) ? CANCEL_MS - elapsed_q[ALPHA_W-1:0]
                                         : elapsed_q[ALPHA_W-1:0];
  assign mul_lo = quot_q * mop_q;

  assign dim_done    = (elapsed_q >= NOW_W'(cfg_i.dim_ms));
  assign hold_done   = (elapsed_q >= NOW_W'(cfg_i.hold_ms));
  assign cancel_done = (elapsed_q >= NOW_W'(CANCEL_MS));

  always_comb begin
    phase_d = phase_q;
    sect_d  = sect_q;
    capt_d  = capt_q;
    alpha_d = '0;
    case (phase_q)
      PH_DIM_INIT: begin
        alpha_d = prod_q;
        if (dim_done) begin
          phase_d = PH_HOLD;
          sect_d  = item_q.now_ms;
        end
      end
      PH_HOLD: begin
        alpha_d = item_q.target;
        if (hold_done) begin
          phase_d = PH_DIM_SLEEP;
          sect_d  = item_q.now_ms;
        end
      end
      PH_DIM_SLEEP: begin
        alpha_d = prod_q + item_q.target;
        if (dim_done) begin
          alpha_d = BLACK;
          phase_d = PH_OFF;
          sect_d  = item_q.now_ms;
        end
      end
      PH_CANCEL: begin
        alpha_d = prod_q;
        if (cancel_done) begin
          alpha_d = '0;
          phase_d = PH_DONE;
          sect_d  = item_q.now_ms;
        end
      end
      PH_OFF: begin
        alpha_d = BLACK;
      end
      default: begin
        alpha_d = '0;
      end
    endcase
    if (item_q.cancel_request && (capt_q == '0) && (phase_d != PH_CANCEL)) begin
      capt_d  = alpha_d;
      phase_d = PH_CANCEL;
      sect_d  = item_q.now_ms;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_result_o = result_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      phase_q       <= PH_DIM_INIT;
      start_phase_q <= PH_DIM_INIT;
      sect_q        <= '0;
      capt_q        <= '0;
      item_q        <= '0;
      elapsed_q     <= '0;
      quot_q        <= '0;
      mop_q         <= '0;
      prod_q        <= '0;
      out_valid_q   <= 1'b0;
      result_q      <= '0;
    end else begin
      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (pop) begin
            item_q        <= q_item_i;
            elapsed_q     <= elapsed_new;
            sect_q        <= sect_cur;
            start_phase_q <= phase_q;
            state_q       <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (div_rsp_i.done) begin
            quot_q  <= div_rsp_i.quot;
            mop_q   <= mop_d;
            state_q <= ST_MUL;
          end
        end
        ST_MUL: begin
          prod_q  <= mul_lo;
          state_q <= ST_FIN;
        end
        ST_FIN: begin
          phase_q                   <= phase_d;
          sect_q                    <= sect_d;
          capt_q                    <= capt_d;
          result_q.alpha            <= alpha_d;
          result_q.redraw           <= (phase_d != PH_HOLD);
          result_q.want_next_frame  <= (phase_d != PH_OFF);
          result_q.finished         <= (phase_d == PH_OFF);
          result_q.cancelled_notify <= (start_phase_q == PH_DONE);
          out_valid_q               <= 1'b1;
          state_q                   <= ST_IDLE;
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== rtl/core/screen_dim_fade_sequencer_unit.sv =====
// ---------------------------------------------------------------------------
// screen_dim_fade_sequencer_unit
// Fade sequencer for a screen-dimming overlay, stepped once per frame event.
// ---------------------------------------------------------------------------
//
//   Port     Role       Carries
//   in_i     sink       now_ms, cancel_request
//   out_o    source     alpha, redraw, want_next_frame, finished, cancelled_notify
//   APB      slave      brightness_percent, dim_ms, hold_ms at 0x0, 0x4, 0x8
//
// Each event passes the front register, the queue and the 32-step divider in
// the back part on its way to a result, and one event is sequenced at a time.
// Reset restores the register defaults and the initial dimming phase at once.
// Two queued events and one front register let input transfers continue while
// a finished result waits on out_o.
//
module screen_dim_fade_sequencer_unit import sdfs_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  sdfs_in_if.sink            in_i,
  sdfs_out_if.source         out_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  cfg_t     cfg_q;
  reg_idx_e reg_sel;
  logic     cfg_wr;
  logic     push;
  item_t    front_item;
  logic     q_ready;
  logic     q_valid;
  item_t    q_item;
  logic     q_pop;
  div_req_t div_req;
  div_rsp_t div_rsp;
  result_t  result;

  assign pready  = 1'b1;
  assign reg_sel = reg_idx_e'(paddr[PADDR_W-1:2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.brightness_percent <= BRIGHT_RST;
      cfg_q.dim_ms             <= DIM_RST;
      cfg_q.hold_ms            <= HOLD_RST;
    end else if (cfg_wr) begin
      case (reg_sel)
        REG_BRIGHTNESS: cfg_q.brightness_percent <= pwdata[BRIGHT_W-1:0];
        REG_DIM_MS:     cfg_q.dim_ms             <= pwdata[MS_W-1:0];
        REG_HOLD_MS:    cfg_q.hold_ms            <= pwdata[MS_W-1:0];
        default:        cfg_q                    <= cfg_q;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_BRIGHTNESS: prdata = PDATA_W'(cfg_q.brightness_percent);
      REG_DIM_MS:     prdata = PDATA_W'(cfg_q.dim_ms);
      REG_HOLD_MS:    prdata = PDATA_W'(cfg_q.hold_ms);
      default:        prdata = '0;
    endcase
  end

  sdfs_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .brightness_i     (cfg_q.brightness_percent),
    .in_valid_i       (in_i.valid),
    .in_ready_o       (in_i.ready),
    .now_ms_i         (in_i.now_ms),
    .cancel_request_i (in_i.cancel_request),
    .push_o           (push),
    .item_o           (front_item),
    .q_ready_i        (q_ready)
  );

  sdfs_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (front_item),
    .ready_o (q_ready),
    .valid_o (q_valid),
    .item_o  (q_item),
    .pop_i   (q_pop)
  );

  sdfs_divider u_divider (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  sdfs_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .q_valid_i    (q_valid),
    .q_item_i     (q_item),
    .q_pop_o      (q_pop),
    .div_req_o    (div_req),
    .div_rsp_i    (div_rsp),
    .out_valid_o  (out_o.valid),
    .out_ready_i  (out_o.ready),
    .out_result_o (result)
  );

  assign out_o.alpha            = result.alpha;
  assign out_o.redraw           = result.redraw;
  assign out_o.want_next_frame  = result.want_next_frame;
  assign out_o.finished         = result.finished;
  assign out_o.cancelled_notify = result.cancelled_notify;

endmodule

// ===== rtl/core/sdfs_checker.sv =====
// ---------------------------------------------------------------------------
// sdfs_checker
// Port-level checks on the result channel of the fade sequencer.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module sdfs_checker import sdfs_pkg::*; (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               out_valid_i,
  input logic               out_ready_i,
  input logic [ALPHA_W-1:0] alpha_i,
  input logic               redraw_i,
  input logic               want_i,
  input logic               finished_i,
  input logic               cancelled_i
);

  `SDFS_ASSERT(a_out_stall_hold, out_valid_i && !out_ready_i |=> out_valid_i && $stable(alpha_i), "stalled result changed")
  `SDFS_ASSERT_IMPL(a_fin_excl, out_valid_i, finished_i != want_i, "finished and next frame disagree")
  `SDFS_ASSERT_IMPL(a_off_black, out_valid_i && finished_i, alpha_i == BLACK, "off without full black")
  `SDFS_ASSERT_IMPL(a_hold_live, out_valid_i && !redraw_i, want_i && !cancelled_i, "bad hold result")

endmodule

bind screen_dim_fade_sequencer_unit sdfs_checker u_sdfs_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .alpha_i     (out_o.alpha),
  .redraw_i    (out_o.redraw),
  .want_i      (out_o.want_next_frame),
  .finished_i  (out_o.finished),
  .cancelled_i (out_o.cancelled_notify)
);

// ===== verif/screen_dim_fade_sequencer_unit_test.sv =====
// ----------------------------------------------------------------------------
// screen_dim_fade_sequencer_unit_test
// Self-checking bench for the fade sequencer. A short table of frame events and
// register writes opens the run, then random events walk the whole fade, from
// the first ramp through hold, ramp to black, off, cancel and done. Every result
// transfer is compared with a typed row result or a cycle-free sequencer model.
// ----------------------------------------------------------------------------
module screen_dim_fade_sequencer_unit_test;
  import sdfs_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned RANDOM_ITEMS = 1500;
  localparam int unsigned CANCEL_FROM  = 800;
  localparam int unsigned END_WAIT     = 100;
  localparam int unsigned QUIET_LIMIT  = 4000;
  localparam int unsigned ROWS         = 17;
  localparam logic [31:0] FADE_STEP    = 32'hFFFF_FFFF / 32'd100;
  localparam logic [31:0] FULL_BLACK   = 32'hFFFF_FFFF;
  localparam logic [31:0] UNDO_MS      = 32'd500;

  typedef enum logic [2:0] {
    FADE_RAMP_IN  = 3'd0,
    FADE_HOLD     = 3'd1,
    FADE_RAMP_OUT = 3'd2,
    FADE_OFF      = 3'd3,
    FADE_CANCEL   = 3'd4,
    FADE_DONE     = 3'd5
  } fade_phase_e;

  typedef struct packed {
    logic        is_cfg;
    reg_idx_e    idx;
    logic [31:0] wdata;
    logic [47:0] now;
    logic        cancel;
    logic        typed;
    result_t     res;
  } fade_row_t;

  localparam result_t RAMP_ZERO = '{32'd0, 1'b1, 1'b1, 1'b0, 1'b0};

  // Opening events stay inside the first ramp so that the random part still
  // sees every later phase.
  fade_row_t plan [ROWS] = '{
    '{1'b0, REG_BRIGHTNESS, 32'd0,          48'd0,             1'b0, 1'b1, RAMP_ZERO},
    '{1'b0, REG_BRIGHTNESS, 32'd0,          48'hFFFF_FFFF_FFFF, 1'b0, 1'b1, RAMP_ZERO},
    '{1'b1, REG_DIM_MS,     32'h0000_FFFF,  48'd0,             1'b0, 1'b0, RAMP_ZERO},
    '{1'b0, REG_BRIGHTNESS, 32'd0,          48'd10,            1'b0, 1'b0, RAMP_ZERO},
    '{1'b0, REG_BRIGHTNESS, 32'd0,          48'd10,            1'b0, 1'b0, RAMP_ZERO},
    '{1'b1, REG_BRIGHTNESS, 32'd0,          48'd0,             1'b0, 1'b0, RAMP_ZERO},
    '{1'b0, REG_BRIGHTNESS, 32'd0,          48'd1000,          1'b0, 1'b0, RAMP_ZERO},
    '{1'b1, REG_BRIGHTNESS, 32'd100,        48'd0,             1'b0, 1'b0, RAMP_ZERO},
    '{1'b0, REG_BRIGHTNESS, 32'd0,          48'd2000,          1'b0, 1'b1, RAMP_ZERO},
    '{1'b1, REG_BRIGHTNESS, 32'hFFFF_FFFF,  48'd0,             1'b0, 1'b0, RAMP_ZERO},
    '{1'b0, REG_BRIGHTNESS, 32'd0,          48'd30000,         1'b0, 1'b0, RAMP_ZERO},
    '{1'b1, REG_DIM_MS,     32'h0001_7532,  48'd0,             1'b0, 1'b0, RAMP_ZERO},
    '{1'b0, REG_BRIGHTNESS, 32'd0,          48'd30000,         1'b0, 1'b0, RAMP_ZERO},
    '{1'b1, REG_DIM_MS,     32'h0000_FFFF,  48'd0,             1'b0, 1'b0, RAMP_ZERO},
    '{1'b1, REG_HOLD_MS,    32'h0000_FFFF,  48'd0,             1'b0, 1'b0, RAMP_ZERO},
    '{1'b1, REG_BRIGHTNESS, 32'hFFFF_FFB2,  48'd0,             1'b0, 1'b0, RAMP_ZERO},
    '{1'b0, REG_BRIGHTNESS, 32'd0,          48'd30100,         1'b0, 1'b0, RAMP_ZERO}
  };

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  sdfs_in_if  in_if ();
  sdfs_out_if out_if ();

  screen_dim_fade_sequencer_unit u_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_if),
    .out_o   (out_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  cfg_t        fade_cfg = '{7'd50, 16'd1000, 16'd5000};
  fade_phase_e fade_phase = FADE_RAMP_IN;
  logic [47:0] section_mark = '0;
  logic [31:0] held_alpha = '0;
  logic [47:0] cur_now = '0;

  result_t     pending_frames [$];
  int unsigned mismatches = 0;
  int unsigned cycles = 0;
  int unsigned quiet = 0;

  function automatic logic [31:0] ratio(input logic [31:0] num, input logic [31:0] den);
    return (den == 32'd0) ? 32'd0 : num / den;
  endfunction

  function automatic result_t advance_fade(input logic [47:0] now, input logic cancel);
    fade_phase_e entry;
    logic [47:0] elapsed;
    logic [31:0] target;
    logic [31:0] alpha;
    logic [63:0] prod;
    result_t     res;
    entry = fade_phase;
    if (section_mark == '0) section_mark = now;
    elapsed = now - section_mark;
    target = FADE_STEP * (32'd100 - {25'd0, fade_cfg.brightness_percent});
    alpha = '0;
    case (fade_phase)
      FADE_RAMP_IN: begin
        prod = {32'd0, ratio(target, {16'd0, fade_cfg.dim_ms})} * {16'd0, elapsed};
        alpha = prod[31:0];
        if (elapsed >= {32'd0, fade_cfg.dim_ms}) begin
          fade_phase = FADE_HOLD;
          section_mark = now;
        end
      end
      FADE_HOLD: begin
        alpha = target;
        if (elapsed >= {32'd0, fade_cfg.hold_ms}) begin
          fade_phase = FADE_RAMP_OUT;
          section_mark = now;
        end
      end
      FADE_RAMP_OUT: begin
        prod = {32'd0, ratio(FULL_BLACK - target, {16'd0, fade_cfg.dim_ms})} *
               {16'd0, elapsed};
        alpha = prod[31:0] + target;
        if (elapsed >= {32'd0, fade_cfg.dim_ms}) begin
          alpha = FULL_BLACK;
          fade_phase = FADE_OFF;
          section_mark = now;
        end
      end
      FADE_CANCEL: begin
        prod = {32'd0, ratio(held_alpha, UNDO_MS)} * ({32'd0, UNDO_MS} - {16'd0, elapsed});
        alpha = prod[31:0];
        if (elapsed >= {16'd0, UNDO_MS}) begin
          alpha = '0;
          fade_phase = FADE_DONE;
          section_mark = now;
        end
      end
      FADE_OFF: begin
        alpha = FULL_BLACK;
      end
      default: begin
        alpha = '0;
      end
    endcase
    if (cancel && held_alpha == '0 && fade_phase != FADE_CANCEL) begin
      held_alpha = alpha;
      fade_phase = FADE_CANCEL;
      section_mark = now;
    end
    res.alpha = alpha;
    res.redraw = (fade_phase != FADE_HOLD);
    res.want_next_frame = (fade_phase != FADE_OFF);
    res.finished = (fade_phase == FADE_OFF);
    res.cancelled_notify = (entry == FADE_DONE);
    return res;
  endfunction

  // Mostly short gaps, now and then a long one, none at all when calm.
  function automatic int unsigned pick_gap(input logic calm);
    int unsigned r;
    r = $urandom_range(0, 31);
    if (calm) return 0;
    if (r == 0) return $urandom_range(10, 60);
    if (r < 20) return 0;
    return $urandom_range(1, 3);
  endfunction

  task automatic send_event(input logic [47:0] now, input logic cancel,
                            input int unsigned gap, input logic typed, input result_t typed_res);
    result_t res;
    if (gap != 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.now_ms <= now;
    in_if.cancel_request <= cancel;
    do @(posedge clk_i); while (in_if.ready !== 1'b1);
    res = advance_fade(now, cancel);
    pending_frames.push_back(typed ? typed_res : res);
  endtask

  task automatic settle();
    in_if.valid <= 1'b0;
    do @(posedge clk_i); while (pending_frames.size() != 0);
  endtask

  task automatic write_reg(input reg_idx_e idx, input logic [31:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= PADDR_W'({idx, 2'b00});
    pwdata <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_BRIGHTNESS: fade_cfg.brightness_percent = data[BRIGHT_W-1:0];
      REG_DIM_MS:     fade_cfg.dim_ms = data[MS_W-1:0];
      REG_HOLD_MS:    fade_cfg.hold_ms = data[MS_W-1:0];
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  initial begin : result_sink
    int unsigned stall;
    stall = 0;
    out_if.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (stall != 0) begin
        stall--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
        stall = pick_gap(((cycles >> 9) & 3) == 1);
      end
    end
  end

  always @(posedge clk_i) begin : result_check
    result_t got;
    result_t want;
    if (rst_ni === 1'b1 && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
      got = '{out_if.alpha, out_if.redraw, out_if.want_next_frame, out_if.finished,
              out_if.cancelled_notify};
      if (pending_frames.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result transfer: alpha=%h redraw=%b next=%b fin=%b cxl=%b",
                   got.alpha, got.redraw, got.want_next_frame, got.finished,
                   got.cancelled_notify);
      end else begin
        want = pending_frames.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result mismatch: expected alpha=%h redraw=%b next=%b fin=%b cxl=%b, got alpha=%h redraw=%b next=%b fin=%b cxl=%b",
                     want.alpha, want.redraw, want.want_next_frame, want.finished,
                     want.cancelled_notify, got.alpha, got.redraw, got.want_next_frame,
                     got.finished, got.cancelled_notify);
        end
      end
    end
  end

  always @(posedge clk_i) begin : watchdog
    cycles++;
    if ((in_if.valid === 1'b1 && in_if.ready === 1'b1) ||
        (out_if.valid === 1'b1 && out_if.ready === 1'b1) || psel === 1'b1) begin
      quiet = 0;
    end else begin
      quiet++;
    end
    if (quiet >= QUIET_LIMIT) begin
      $display("screen_dim_fade_sequencer_unit_test failed");
      $finish;
    end
  end

  initial begin : stimulus
    logic [31:0] wdata;
    logic [31:0] span;
    logic        cancel;
    int unsigned r;
    rst_ni <= 1'b0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    in_if.valid <= 1'b0;
    in_if.now_ms <= '0;
    in_if.cancel_request <= 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int unsigned k = 0; k < ROWS; k++) begin
      if (plan[k].is_cfg) begin
        settle();
        write_reg(plan[k].idx, plan[k].wdata);
      end else begin
        send_event(plan[k].now, plan[k].cancel, pick_gap(1'b0), plan[k].typed, plan[k].res);
        cur_now = plan[k].now;
      end
    end

    for (int unsigned n = 0; n < RANDOM_ITEMS; n++) begin
      if (n != 0 && n % 100 == 0) begin
        settle();
        if ($urandom_range(0, 1) == 1) begin
          wdata = $urandom;
          case ($urandom_range(0, 4))
            0: wdata[6:0] = 7'd0;
            1: wdata[6:0] = 7'd100;
            2: wdata[6:0] = 7'd127;
            default: ;
          endcase
          write_reg(REG_BRIGHTNESS, wdata);
        end
        if ($urandom_range(0, 1) == 1) begin
          wdata = $urandom;
          case ($urandom_range(0, 11))
            0: wdata[15:0] = 16'd0;
            1: wdata[15:0] = 16'd1;
            2: wdata[15:0] = 16'hFFFF;
            default: wdata[15:0] = 16'($urandom_range(2000, 65535));
          endcase
          write_reg(REG_DIM_MS, wdata);
        end
        if ($urandom_range(0, 1) == 1) begin
          wdata = $urandom;
          case ($urandom_range(0, 9))
            0: wdata[15:0] = 16'd0;
            1: wdata[15:0] = 16'hFFFF;
            default: wdata[15:0] = 16'($urandom_range(1, 65535));
          endcase
          write_reg(REG_HOLD_MS, wdata);
        end
      end

      // Time mostly advances in small steps against the length of the current phase,
      // with rare jumps and steps back, so that each phase lasts for a good number of frames.
      case (fade_phase)
        FADE_RAMP_IN, FADE_RAMP_OUT: span = {16'd0, fade_cfg.dim_ms};
        FADE_HOLD:                   span = {16'd0, fade_cfg.hold_ms};
        FADE_CANCEL:                 span = UNDO_MS;
        default:                     span = 32'd1000;
      endcase
      r = $urandom_range(0, 299);
      if (r == 0) begin
        cur_now[47:32] = 16'($urandom);
        cur_now[31:0] = $urandom;
      end else if (r < 3) begin
        cur_now = cur_now - 48'($urandom_range(1, 2000));
      end else begin
        cur_now = cur_now + 48'($urandom_range(0, span / 100 + 1));
      end

      if (fade_phase == FADE_CANCEL || fade_phase == FADE_DONE)
        cancel = 1'($urandom_range(0, 1));
      else
        cancel = (n >= CANCEL_FROM) && ($urandom_range(0, 39) == 0);

      send_event(cur_now, cancel, pick_gap(((n >> 6) & 3) == 3), 1'b0, RAMP_ZERO);
    end

    settle();
    repeat (END_WAIT) @(posedge clk_i);
    if (mismatches == 0 && pending_frames.size() == 0) begin
      $display("screen_dim_fade_sequencer_unit_test passed");
    end else begin
      $display("screen_dim_fade_sequencer_unit_test failed");
    end
    $finish;
  end

endmodule
